### src/yuvb_pkg.sv
// ----------------------------------------------------------------------------
// YUV 4:1:1 to BGR converter package
// Shared types and constants for the group queue, the pixel lanes and the
// output serializer.
// ----------------------------------------------------------------------------
package yuvb_pkg;

  // One lane per pixel of a UYYVYY group.
  localparam int LANES     = 4;
  localparam int PIX_IDX_W = $clog2(LANES);

  typedef logic [PIX_IDX_W-1:0] pix_idx_t;
  localparam pix_idx_t LAST_PIX = pix_idx_t'(LANES - 1);

  // Signed accumulator wide enough for every BT.601 sum.
  typedef logic signed [18:0] acc_t;

  localparam acc_t C_Y   = 19'sd298;
  localparam acc_t C_UB  = 19'sd516;
  localparam acc_t C_UG  = 19'sd100;
  localparam acc_t C_VG  = 19'sd208;
  localparam acc_t C_VR  = 19'sd409;
  localparam acc_t OFS_Y = 19'sd16;
  localparam acc_t OFS_C = 19'sd128;

  // A group ready for the lanes: per-pixel luma and interpolated chroma.
  typedef struct packed {
    logic [LANES-1:0][7:0] y;
    logic [LANES-1:0][7:0] cb;
    logic [LANES-1:0][7:0] cr;
    logic                  run_last;
    logic                  line_last;
  } group_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

endpackage

### src/yuv411_to_bgr_converter_top.sv
// Flow: a group enters the group queue at the transfer that releases it (the next
//   group, or its own transfer on a line end), then the serializer's pixel bank when idle.
// Throughput: one pixel per cycle while out_ready stays high, set by the one-pixel
//   output serializer; a new input is taken whenever the two-entry group queue
//   is empty. Reset (rst, synchronous) empties the queue and drops any held group.
// ----------------------------------------------------------------------------
// YUV 4:1:1 to BGR converter top level
// Front end with chroma interpolation, four parallel conversion lanes and an
// output serializer.
// ----------------------------------------------------------------------------
module yuv411_to_bgr_converter_top import yuvb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] u_sample,
  input  logic [7:0] luma0,
  input  logic [7:0] luma1,
  input  logic [7:0] v_sample,
  input  logic [7:0] luma2,
  input  logic [7:0] luma3,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] blue,
  output logic [7:0] green,
  output logic [7:0] red,
  output logic       run_last,
  output logic       line_last
);

  logic               job_valid;
  logic               job_take;
  group_t             job;
  pixel_t [LANES-1:0] lane_pix;

  yuvb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .u_sample  (u_sample),
    .luma0     (luma0),
    .luma1     (luma1),
    .v_sample  (v_sample),
    .luma2     (luma2),
    .luma3     (luma3),
    .line_end  (line_end),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    yuvb_lane u_lane (
      .y   (job.y[k]),
      .cb  (job.cb[k]),
      .cr  (job.cr[k]),
      .pix (lane_pix[k])
    );
  end

  yuvb_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_run_last  (job.run_last),
    .job_line_last (job.line_last),
    .lane_pix      (lane_pix),
    .job_take      (job_take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .blue          (blue),
    .green         (green),
    .red           (red),
    .run_last      (run_last),
    .line_last     (line_last)
  );

endmodule

### src/yuvb_front.sv
// ----------------------------------------------------------------------------
// YUV 4:1:1 group front end
// Holds the last group until its right neighbor arrives, interpolates the
// chroma of each pixel and queues up to two finished groups for the lanes.
// ----------------------------------------------------------------------------
module yuvb_front import yuvb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] u_sample,
  input  logic [7:0] luma0,
  input  logic [7:0] luma1,
  input  logic [7:0] v_sample,
  input  logic [7:0] luma2,
  input  logic [7:0] luma3,
  input  logic       line_end,
  output logic       job_valid,
  output group_t     job,
  input  logic       job_take
);

  logic                  held_valid;
  logic [7:0]            held_u;
  logic [7:0]            held_v;
  logic [LANES-1:0][7:0] held_lumas;
  logic [7:0]            before_v;
  logic [7:0]            v0_next;
  logic [LANES-1:0][7:0] lumas_in;
  group_t                queue [2];
  logic [1:0]            count;
  logic                  in_xfer;
  group_t                job_a;
  group_t                job_b;

  // Truncating quarter and half weights between neighboring chroma samples.
  function automatic group_t make_group(input logic [LANES-1:0][7:0] lumas,
                                        input logic [7:0] u, input logic [7:0] v,
                                        input logic [7:0] v0, input logic [7:0] u1,
                                        input logic [7:0] v1, input logic run_l,
                                        input logic line_l);
    group_t     grp;
    logic [9:0] u3;
    logic [9:0] u13;
    logic [9:0] v3;
    u3            = {1'b0, u, 1'b0} + {2'b00, u};
    u13           = {1'b0, u1, 1'b0} + {2'b00, u1};
    v3            = {1'b0, v, 1'b0} + {2'b00, v};
    grp.y         = lumas;
    grp.cb[0]     = u;
    grp.cb[1]     = u3[9:2] + {2'b00, u1[7:2]};
    grp.cb[2]     = {1'b0, u[7:1]} + {1'b0, u1[7:1]};
    grp.cb[3]     = {2'b00, u[7:2]} + u13[9:2];
    grp.cr[0]     = {1'b0, v0[7:1]} + {1'b0, v[7:1]};
    grp.cr[1]     = {2'b00, v0[7:2]} + v3[9:2];
    grp.cr[2]     = v;
    grp.cr[3]     = v3[9:2] + {2'b00, v1[7:2]};
    grp.run_last  = run_l;
    grp.line_last = line_l;
    return grp;
  endfunction

  // New transfers are taken only into an empty queue, so both slots are free.
  assign in_ready  = (count == 2'd0);
  assign in_xfer   = in_valid && in_ready;
  assign job_valid = (count != 2'd0);
  assign job       = queue[0];
  assign lumas_in  = {luma3, luma2, luma1, luma0};
  assign v0_next   = held_valid ? held_v : v_sample;

  always_comb begin
    job_a = make_group(held_lumas, held_u, held_v, before_v, u_sample, v_sample,
                       !line_end, 1'b0);
    job_b = make_group(lumas_in, u_sample, v_sample, v0_next, u_sample, v_sample,
                       1'b1, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      count      <= 2'd0;
    end else if (in_xfer) begin
      held_valid <= !line_end;
      count      <= {1'b0, held_valid} + {1'b0, line_end};
    end else if (job_take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      before_v   <= v0_next;
      held_u     <= u_sample;
      held_v     <= v_sample;
      held_lumas <= lumas_in;
      queue[0]   <= held_valid ? job_a : job_b;
      queue[1]   <= job_b;
    end else if (job_take) begin
      queue[0] <= queue[1];
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("group queue holds more than two entries");

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    in_xfer && line_end |=> !held_valid && count != 2'd0)
    else $error("line end left a group held or queued nothing");
`endif

endmodule

### src/yuvb_lane.sv
// ----------------------------------------------------------------------------
// YUV to BGR pixel lane
// Converts one pixel with BT.601 integer coefficients, floor shift by 8 and
// clamping to 0..255.
// ----------------------------------------------------------------------------
module yuvb_lane import yuvb_pkg::*; (
  input  logic [7:0] y,
  input  logic [7:0] cb,
  input  logic [7:0] cr,
  output pixel_t     pix
);

  acc_t yy;
  acc_t uu;
  acc_t vv;
  acc_t b_acc;
  acc_t g_acc;
  acc_t r_acc;

  // A negative sum clamps to zero; 65536 and above clamps to full scale.
  function automatic logic [7:0] clamp_shift(input acc_t acc);
    logic [7:0] res;
    if (acc[18]) begin
      res = 8'd0;
    end else if (|acc[17:16]) begin
      res = 8'hFF;
    end else begin
      res = acc[15:8];
    end
    return res;
  endfunction

  always_comb begin
    yy    = $signed({11'd0, y}) - OFS_Y;
    uu    = $signed({11'd0, cb}) - OFS_C;
    vv    = $signed({11'd0, cr}) - OFS_C;
    b_acc = C_Y * yy + C_UB * uu;
    g_acc = C_Y * yy - C_UG * uu - C_VG * vv;
    r_acc = C_Y * yy + C_VR * vv;
    pix.b = clamp_shift(b_acc);
    pix.g = clamp_shift(g_acc);
    pix.r = clamp_shift(r_acc);
  end

endmodule

### src/yuvb_merge.sv
// ----------------------------------------------------------------------------
// YUV to BGR output serializer
// Registers the four lane results of a group and hands them out one pixel
// per transfer, reloading on the last pixel without a bubble.
// ----------------------------------------------------------------------------
module yuvb_merge import yuvb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  logic                   job_run_last,
  input  logic                   job_line_last,
  input  pixel_t [LANES-1:0]     lane_pix,
  output logic                   job_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             blue,
  output logic [7:0]             green,
  output logic [7:0]             red,
  output logic                   run_last,
  output logic                   line_last
);

  logic               bank_valid;
  pixel_t [LANES-1:0] bank_pix;
  logic               bank_run;
  logic               bank_line;
  pix_idx_t           idx;
  logic               out_xfer;
  logic               at_last;

  assign at_last   = (idx == LAST_PIX);
  assign out_xfer  = out_valid && out_ready;
  assign job_take  = job_valid && (!bank_valid || (out_ready && at_last));
  assign out_valid = bank_valid;
  assign blue      = bank_pix[idx].b;
  assign green     = bank_pix[idx].g;
  assign red       = bank_pix[idx].r;
  assign run_last  = bank_run && at_last;
  assign line_last = bank_line && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      idx        <= '0;
    end else if (job_take) begin
      bank_valid <= 1'b1;
      idx        <= '0;
    end else if (out_xfer) begin
      idx <= idx + pix_idx_t'(1);
      if (at_last) begin
        bank_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      bank_pix  <= lane_pix;
      bank_run  <= job_run_last;
      bank_line <= job_line_last;
    end
  end

`ifndef SYNTH
  a_line_needs_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_last |-> run_last)
    else $error("line end flagged on a pixel that does not close its run");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    job_take |-> !bank_valid || (out_ready && at_last))
    else $error("group loaded over pixels still waiting");

  a_bank_drains: assert property (@(posedge clk) disable iff (rst)
    out_xfer && at_last && !job_valid |=> !bank_valid)
    else $error("pixel bank stayed valid after its last transfer");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUV 4:1:1 to BGR converter testbench
// Sends UYYVYY groups through the input channel and predicts the BGR pixels
// that each transfer releases. Every pixel taken from the output channel is
// checked field by field against the oldest prediction. Directed corner
// groups come first, then random video lines under changing back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import yuvb_pkg::*;

  typedef struct packed {
    logic [7:0]            u;
    logic [LANES-1:0][7:0] ys;
    logic [7:0]            v;
    logic                  eol;
  } group_in_t;

  typedef struct {
    group_in_t grp;
    int        tx_idle;
    int        rx_idle;
    logic      drain;
    logic      hold;
  } pending_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       run_last;
    logic       line_last;
  } bgr_exp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] u_sample = '0;
  logic [7:0] luma0 = '0;
  logic [7:0] luma1 = '0;
  logic [7:0] v_sample = '0;
  logic [7:0] luma2 = '0;
  logic [7:0] luma3 = '0;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       run_last;
  logic       line_last;

  pending_t  pending[$];
  bgr_exp_t  exp_pixels[$];
  group_in_t cur_group;
  int        errors = 0;
  int        rx_idle_pct = 0;
  logic      hold_req = 1'b0;
  int        hold_left = 0;
  int        fill_tx_idle = 0;
  int        fill_rx_idle = 0;

  // Converter state mirrored on the input side.
  logic                  held_valid = 1'b0;
  logic [7:0]            held_u = '0;
  logic [7:0]            held_v = '0;
  logic [LANES-1:0][7:0] held_lumas = '0;
  logic [7:0]            prev_v = '0;

  yuv411_to_bgr_converter_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .u_sample(u_sample),
    .luma0(luma0),
    .luma1(luma1),
    .v_sample(v_sample),
    .luma2(luma2),
    .luma3(luma3),
    .line_end(line_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .blue(blue),
    .green(green),
    .red(red),
    .run_last(run_last),
    .line_last(line_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] clamp_byte(int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic bgr_exp_t bt601_pixel(logic [7:0] y, int cb, int cr);
    bgr_exp_t px;
    int yy;
    int uu;
    int vv;
    yy = int'(y) - 16;
    uu = cb - 128;
    vv = cr - 128;
    px.b = clamp_byte(298 * yy + 516 * uu);
    px.g = clamp_byte(298 * yy - 100 * uu - 208 * vv);
    px.r = clamp_byte(298 * yy + 409 * vv);
    px.run_last = 1'b0;
    px.line_last = 1'b0;
    return px;
  endfunction

  // Chroma is interpolated between the previous V and the next U and V,
  // with every quarter and half weight truncated on its own.
  task automatic push_group_pixels(logic [LANES-1:0][7:0] lumas, int u, int v,
                                   int v0, int u1, int v1);
    int cb[LANES];
    int cr[LANES];
    cb[0] = u;
    cr[0] = v0 / 2 + v / 2;
    cb[1] = (3 * u) / 4 + u1 / 4;
    cr[1] = v0 / 4 + (3 * v) / 4;
    cb[2] = u / 2 + u1 / 2;
    cr[2] = v;
    cb[3] = u / 4 + (3 * u1) / 4;
    cr[3] = (3 * v) / 4 + v1 / 4;
    for (int k = 0; k < LANES; k++)
      exp_pixels.push_back(bt601_pixel(lumas[k], cb[k], cr[k]));
  endtask

  task automatic predict_pixels(group_in_t g);
    int n;
    n = 0;
    if (held_valid) begin
      push_group_pixels(held_lumas, int'(held_u), int'(held_v), int'(prev_v),
                        int'(g.u), int'(g.v));
      prev_v = held_v;
      n = LANES;
    end else begin
      prev_v = g.v;
    end
    if (g.eol) begin
      // The last group of a line uses its own chroma as the next chroma.
      push_group_pixels(g.ys, int'(g.u), int'(g.v), int'(prev_v), int'(g.u),
                        int'(g.v));
      exp_pixels[exp_pixels.size() - 1].line_last = 1'b1;
      held_valid = 1'b0;
      n += LANES;
    end else begin
      held_u = g.u;
      held_v = g.v;
      held_lumas = g.ys;
      held_valid = 1'b1;
    end
    if (n > 0)
      exp_pixels[exp_pixels.size() - 1].run_last = 1'b1;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      $display("%t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Input side: offer the next group, predict its pixels on transfer.
  always @(posedge clk) begin : input_driver
    pending_t nxt;
    logic     take;
    logic     req;
    req = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predict_pixels(cur_group);
      if (!in_valid || in_ready) begin
        take = 1'b0;
        if (pending.size() != 0) begin
          nxt = pending[0];
          if (!(nxt.drain && exp_pixels.size() != 0))
            take = ($urandom_range(0, 99) >= nxt.tx_idle);
        end
        if (take) begin
          void'(pending.pop_front());
          cur_group <= nxt.grp;
          u_sample <= nxt.grp.u;
          luma0 <= nxt.grp.ys[0];
          luma1 <= nxt.grp.ys[1];
          v_sample <= nxt.grp.v;
          luma2 <= nxt.grp.ys[2];
          luma3 <= nxt.grp.ys[3];
          line_end <= nxt.grp.eol;
          rx_idle_pct <= nxt.rx_idle;
          req = nxt.hold;
        end
        in_valid <= take;
      end
    end
    hold_req <= req;
  end

  // Output side ready, with a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : pixel_monitor
    bgr_exp_t want;
    if (!rst && out_valid && out_ready) begin
      if (exp_pixels.size() == 0) begin
        $display("%t: unexpected pixel b=%0d g=%0d r=%0d", $time, blue, green, red);
        errors++;
      end else begin
        want = exp_pixels.pop_front();
        check_field("blue", blue, want.b);
        check_field("green", green, want.g);
        check_field("red", red, want.r);
        check_field("run_last", {7'd0, run_last}, {7'd0, want.run_last});
        check_field("line_last", {7'd0, line_last}, {7'd0, want.line_last});
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return ($urandom_range(0, 1) != 0) ? 8'd16 : 8'd235;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_group(logic [7:0] u, logic [7:0] y0, logic [7:0] y1,
                           logic [7:0] v, logic [7:0] y2, logic [7:0] y3,
                           logic eol);
    pending_t p;
    p.grp.u = u;
    p.grp.ys = {y3, y2, y1, y0};
    p.grp.v = v;
    p.grp.eol = eol;
    p.tx_idle = fill_tx_idle;
    p.rx_idle = fill_rx_idle;
    p.drain = 1'b0;
    p.hold = 1'b0;
    pending.push_back(p);
  endtask

  task automatic add_random_lines(int count, int hold_at);
    int sent;
    int len;
    logic noisy;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        add_group(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                  rand_byte(), noisy ? 1'($urandom_range(0, 1)) : (k == len - 1));
        if (sent == hold_at)
          pending[pending.size() - 1].hold = 1'b1;
        sent++;
      end
    end
  endtask

  initial begin
    fill_tx_idle = 11;
    fill_rx_idle = 64;
    // Single-group lines: both extremes, then neutral chroma with black and white luma.
    add_group(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    add_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    add_group(8'd128, 8'd16, 8'd235, 8'd128, 8'd16, 8'd235, 1'b1);
    // Alternating bit patterns toggle every input bit.
    add_group(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
    add_group(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
    // Lines of three, two and four groups with chroma swinging hard.
    add_group(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    add_group(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
    add_group(8'd0, 8'd128, 8'd64, 8'd255, 8'd32, 8'd200, 1'b1);
    add_group(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
    add_group(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
    add_group(8'd255, 8'd16, 8'd16, 8'd0, 8'd16, 8'd16, 1'b0);
    add_group(8'd0, 8'd235, 8'd235, 8'd255, 8'd235, 8'd235, 1'b0);
    add_group(8'd240, 8'd100, 8'd150, 8'd16, 8'd200, 8'd50, 1'b0);
    add_group(8'd16, 8'd60, 8'd90, 8'd240, 8'd120, 8'd180, 1'b1);
    // A group left held while the sender waits for the output to drain.
    add_group(8'd100, 8'd50, 8'd200, 8'd150, 8'd25, 8'd75, 1'b0);
    add_group(8'd30, 8'd10, 8'd20, 8'd220, 8'd250, 8'd5, 1'b1);
    pending[pending.size() - 1].drain = 1'b1;

    add_random_lines(90, 40);
    fill_tx_idle = 64;
    fill_rx_idle = 11;
    add_random_lines(90, -1);
    pending[pending.size() - 90].drain = 1'b1;
    fill_tx_idle = 0;
    fill_rx_idle = 0;
    add_random_lines(90, 30);
    pending[pending.size() - 1].grp.eol = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (exp_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
